// ===== sv/itchdp_pkg.sv =====
// Shared types, codes and constants for the ITCH datagram parser.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package itchdp_pkg;

	// Byte counter width: holds the largest receive buffer size (65536).
	localparam int POS_W = 17;
	localparam int MAX_DGRAM_DEFAULT = 65536;

	// Depth of the record queue between the byte front end and the result pipeline.
	localparam int QDEPTH = 4;

	// Timestamp decomposition: 7 hour bits, 6 minute bits, 6 second bits, 10 ms bits.
	localparam int TS_W = 48;
	localparam int QUO_W = 29;
	localparam int STEP_COUNT = QUO_W;

	localparam logic [TS_W-1:0] NS_HOUR = 48'd3600000000000;
	localparam logic [TS_W-1:0] NS_MIN = 48'd60000000000;
	localparam logic [TS_W-1:0] NS_SEC = 48'd1000000000;
	localparam logic [TS_W-1:0] NS_MS = 48'd1000000;

	// Message type characters.
	localparam logic [7:0] TYPE_SYS = 8'h53;       // 'S'
	localparam logic [7:0] TYPE_ADD = 8'h41;       // 'A'
	localparam logic [7:0] TYPE_TRADE = 8'h50;     // 'P'
	localparam logic [7:0] TYPE_DIR = 8'h4C;       // 'L'
	localparam logic [7:0] TYPE_DELETE = 8'h44;    // 'D'
	localparam logic [7:0] TYPE_REPLACE = 8'h55;   // 'U'
	localparam logic [7:0] TYPE_CANCEL = 8'h58;    // 'X'
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// Result kinds.
	localparam logic [3:0] KIND_SYS = 4'd0;
	localparam logic [3:0] KIND_ADD = 4'd1;
	localparam logic [3:0] KIND_TRADE = 4'd2;
	localparam logic [3:0] KIND_DIR = 4'd3;
	localparam logic [3:0] KIND_DELETE = 4'd4;
	localparam logic [3:0] KIND_REPLACE = 4'd5;
	localparam logic [3:0] KIND_CANCEL = 4'd6;
	localparam logic [3:0] KIND_UNKNOWN = 4'd7;
	localparam logic [3:0] KIND_INCOMPLETE = 4'd8;
	localparam logic [3:0] KIND_SHORT = 4'd9;
	localparam logic [3:0] KIND_RUNT = 4'd10;
	localparam logic [3:0] KIND_EMPTY = 4'd11;

	// Minimum message lengths per type.
	localparam logic [15:0] MIN_SYS = 16'd12;
	localparam logic [15:0] MIN_ADD = 16'd36;
	localparam logic [15:0] MIN_TRADE = 16'd44;
	localparam logic [15:0] MIN_DIR = 16'd22;
	localparam logic [15:0] MIN_DELETE = 16'd19;
	localparam logic [15:0] MIN_REPLACE = 16'd35;
	localparam logic [15:0] MIN_CANCEL = 16'd23;

	// Byte positions within a datagram.
	localparam logic [POS_W-1:0] POS_LEN_HI = 17'd0;
	localparam logic [POS_W-1:0] POS_LEN_LO = 17'd1;
	localparam logic [POS_W-1:0] POS_TYPE = 17'd2;
	localparam logic [POS_W-1:0] POS_TIME_FIRST = 17'd7;
	localparam logic [POS_W-1:0] POS_TIME_LAST = 17'd12;
	localparam logic [POS_W-1:0] POS_EVENT = 17'd13;
	localparam logic [POS_W-1:0] POS_SIDE = 17'd21;
	localparam logic [POS_W-1:0] POS_SYM_LATE_FIRST = 17'd26;
	localparam logic [POS_W-1:0] POS_SYM_LATE_LAST = 17'd33;
	localparam logic [POS_W-1:0] POS_SYM_DIR_FIRST = 17'd3;
	localparam logic [POS_W-1:0] POS_SYM_DIR_LAST = 17'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       datagram_end;
	} in_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] message_length;
		logic [7:0]  type_byte;
		logic [6:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [9:0]  millis;
		logic [7:0]  evt_byte;
		logic [7:0]  side_code;
		logic [63:0] symbol;
		logic [3:0]  symbol_length;
	} out_t;

	// Captured state of one finished datagram.
	typedef struct packed {
		logic [POS_W-1:0] byte_count;
		logic [15:0]      length_field;
		logic [7:0]       message_type;
		logic [TS_W-1:0]  time_stamp;
		logic [7:0]       event_capture;
		logic [7:0]       side_capture;
		logic [63:0]      symbol_capture;
	} rec_t;

	// Divisor used by each compare-subtract step of the timestamp pipeline.
	function automatic logic [TS_W-1:0] step_div(input int k);
		logic [TS_W-1:0] d;
		if (k < 7) begin
			d = NS_HOUR << (6 - k);
		end else if (k < 13) begin
			d = NS_MIN << (12 - k);
		end else if (k < 19) begin
			d = NS_SEC << (18 - k);
		end else begin
			d = NS_MS << (28 - k);
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== sv/itch_datagram_parser.sv =====
// ITCH datagram parser: one byte accepted per cycle while the record queue has room, one result per datagram.
// A result shows once the datagram's record has passed through the record queue, the
// 29-stage timestamp compare-subtract pipeline and the output register.
// Bytes flow one per cycle while the queue has room; results leave one per cycle while res_ready is high.
// A four-record queue lets bytes keep flowing while the result side is stalled.
// Reset clears the capture state, the queue and all pipeline valid bits at once.
`default_nettype none

module itch_datagram_parser import itchdp_pkg::*; #(
	parameter int MAX_DATAGRAM_BYTES = MAX_DGRAM_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic byte_valid,
	output logic      byte_ready,
	input  wire in_t  byte_data,
	output logic      res_valid,
	input  wire logic res_ready,
	output out_t      res_data
);

	logic q_full;
	logic push;
	rec_t wr_rec;
	logic pop;
	rec_t head;
	logic head_valid;

	itchdp_front #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.q_full(q_full),
		.push(push),
		.rec(wr_rec)
	);

	itchdp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_rec(wr_rec),
		.pop(pop),
		.rd_rec(head),
		.not_empty(head_valid),
		.full(q_full)
	);

	itchdp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

endmodule

`default_nettype wire

// ===== sv/itchdp_front.sv =====
// Byte front end: takes one datagram byte per cycle while the queue is not full and captures header fields.
// Pushes one record per datagram into the queue. Depends on itchdp_pkg.
`default_nettype none

module itchdp_front import itchdp_pkg::*; #(
	parameter int MAX_DATAGRAM_BYTES = MAX_DGRAM_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic byte_valid,
	output logic      byte_ready,
	input  wire in_t  byte_data,
	input  wire logic q_full,
	output logic      push,
	output rec_t      rec
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      len_q, len_d;
	logic [7:0]       type_q, type_d;
	logic [TS_W-1:0]  time_q, time_d;
	logic [7:0]       event_q, event_d;
	logic [7:0]       side_q, side_d;
	logic [63:0]      sym_q, sym_d;
	logic             accept;
	logic             take;
	logic             sym_late;
	logic [7:0]       b;

	assign byte_ready = !q_full;
	assign accept = byte_valid && byte_ready;
	assign push = accept && byte_data.datagram_end;
	assign b = byte_data.data_byte;

	// Bytes past the receive buffer size are dropped and the count saturates.
	assign take = accept && (pos_q < POS_W'(MAX_DATAGRAM_BYTES));
	assign sym_late = (type_q == TYPE_ADD) || (type_q == TYPE_TRADE) || (type_q == TYPE_REPLACE);

	always_comb begin
		pos_d = pos_q;
		len_d = len_q;
		type_d = type_q;
		time_d = time_q;
		event_d = event_q;
		side_d = side_q;
		sym_d = sym_q;
		if (take) begin
			pos_d = pos_q + POS_W'(1);
			if (pos_q == POS_LEN_HI) begin
				len_d = {b, 8'h00};
			end else if (pos_q == POS_LEN_LO) begin
				len_d = {len_q[15:8], b};
			end else if (pos_q == POS_TYPE) begin
				type_d = b;
			end
			if (pos_q >= POS_TIME_FIRST && pos_q <= POS_TIME_LAST) begin
				time_d = {time_q[TS_W-9:0], b};
			end
			if (pos_q == POS_EVENT) begin
				event_d = b;
			end
			if (pos_q == POS_SIDE) begin
				side_d = b;
			end
			if ((sym_late && pos_q >= POS_SYM_LATE_FIRST && pos_q <= POS_SYM_LATE_LAST) ||
			    (type_q == TYPE_DIR && pos_q >= POS_SYM_DIR_FIRST && pos_q <= POS_SYM_DIR_LAST)) begin
				sym_d = {sym_q[55:0], b};
			end
		end
	end

	assign rec.byte_count = pos_d;
	assign rec.length_field = len_d;
	assign rec.message_type = type_d;
	assign rec.time_stamp = time_d;
	assign rec.event_capture = event_d;
	assign rec.side_capture = side_d;
	assign rec.symbol_capture = sym_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			type_q <= '0;
			time_q <= '0;
			event_q <= '0;
			side_q <= '0;
			sym_q <= '0;
		end else if (accept) begin
			if (byte_data.datagram_end) begin
				pos_q <= '0;
				len_q <= '0;
				type_q <= '0;
				time_q <= '0;
				event_q <= '0;
				side_q <= '0;
				sym_q <= '0;
			end else begin
				pos_q <= pos_d;
				len_q <= len_d;
				type_q <= type_d;
				time_q <= time_d;
				event_q <= event_d;
				side_q <= side_d;
				sym_q <= sym_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/itchdp_fifo.sv =====
// Short record queue between the byte front end and the result pipeline.
// Holds finished datagram records; depends on itchdp_pkg.
`default_nettype none

module itchdp_fifo import itchdp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t wr_rec,
	input  wire logic pop,
	output rec_t      rd_rec,
	output logic      not_empty,
	output logic      full
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	rec_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign rd_rec = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign full = (cnt_q == CNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/itchdp_back.sv =====
// Result pipeline: classifies a datagram record and splits its timestamp
// with one constant compare-subtract per stage, then holds the result. Depends on itchdp_pkg.
`default_nettype none

module itchdp_back import itchdp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rec_t head,
	input  wire logic head_valid,
	output logic      pop,
	output logic      res_valid,
	input  wire logic res_ready,
	output out_t      res_data
);

	localparam int NSTEP = STEP_COUNT;

	logic             adv;
	out_t             hd_info;
	logic             hd_tm;

	logic             vld_in [NSTEP];
	logic [TS_W-1:0]  rem_in [NSTEP];
	logic [QUO_W-1:0] quo_in [NSTEP];
	out_t             info_in [NSTEP];
	logic             tm_in [NSTEP];
	logic             ge [NSTEP];
	logic [TS_W-1:0]  rem_nx [NSTEP];
	logic [QUO_W-1:0] quo_nx [NSTEP];

	logic             vld_s [NSTEP];
	logic [TS_W-1:0]  rem_s [NSTEP];
	logic [QUO_W-1:0] quo_s [NSTEP];
	out_t             info_s [NSTEP];
	logic             tm_s [NSTEP];

	logic             res_valid_q;
	out_t             res_q;
	out_t             res_nx;

	// The whole pipeline moves together whenever the output register can take a result.
	assign adv = !res_valid_q || res_ready;
	assign pop = adv && head_valid;
	assign res_valid = res_valid_q;
	assign res_data = res_q;

	// Classification of the record at the queue head.
	always_comb begin
		logic [POS_W:0]  n_ext;
		logic [POS_W:0]  need;
		logic [15:0]     minlen;
		logic [3:0]      kind;
		logic            known;
		logic            has_event;
		logic            has_side;
		logic            has_sym;
		logic            has_time;
		logic            all_sp;
		logic [3:0]      sp_cnt;

		n_ext = {1'b0, head.byte_count};
		need = (POS_W + 1)'(head.length_field) + (POS_W + 1)'(2);
		minlen = '0;
		kind = KIND_UNKNOWN;
		known = 1'b1;
		has_time = 1'b0;
		has_event = 1'b0;
		has_side = 1'b0;
		has_sym = 1'b0;

		unique case (head.message_type)
			TYPE_SYS: begin
				kind = KIND_SYS; minlen = MIN_SYS; has_time = 1'b1; has_event = 1'b1;
			end
			TYPE_ADD: begin
				kind = KIND_ADD; minlen = MIN_ADD; has_time = 1'b1; has_side = 1'b1;
				has_sym = 1'b1;
			end
			TYPE_TRADE: begin
				kind = KIND_TRADE; minlen = MIN_TRADE; has_time = 1'b1; has_side = 1'b1;
				has_sym = 1'b1;
			end
			TYPE_DIR: begin
				kind = KIND_DIR; minlen = MIN_DIR; has_sym = 1'b1;
			end
			TYPE_DELETE: begin
				kind = KIND_DELETE; minlen = MIN_DELETE; has_time = 1'b1;
			end
			TYPE_REPLACE: begin
				kind = KIND_REPLACE; minlen = MIN_REPLACE; has_time = 1'b1; has_side = 1'b1;
				has_sym = 1'b1;
			end
			TYPE_CANCEL: begin
				kind = KIND_CANCEL; minlen = MIN_CANCEL; has_time = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase

		// Trailing spaces sit in the low bytes of the symbol.
		all_sp = 1'b1;
		sp_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			if (all_sp && head.symbol_capture[i*8 +: 8] == SPACE_CHAR) begin
				sp_cnt = sp_cnt + 4'd1;
			end else begin
				all_sp = 1'b0;
			end
		end

		hd_info = '0;
		hd_tm = 1'b0;
		if (n_ext < (POS_W + 1)'(2)) begin
			hd_info.kind = KIND_RUNT;
		end else if (n_ext < need) begin
			hd_info.kind = KIND_INCOMPLETE;
			hd_info.message_length = head.length_field;
			hd_info.type_byte = head.message_type;
		end else if (head.length_field == '0) begin
			hd_info.kind = KIND_EMPTY;
			hd_info.message_length = head.length_field;
		end else begin
			hd_info.message_length = head.length_field;
			hd_info.type_byte = head.message_type;
			if (!known) begin
				hd_info.kind = KIND_UNKNOWN;
			end else if (head.length_field < minlen) begin
				hd_info.kind = KIND_SHORT;
			end else begin
				hd_info.kind = kind;
				hd_tm = has_time;
				if (has_event) begin
					hd_info.evt_byte = head.event_capture;
				end
				if (has_side) begin
					hd_info.side_code = head.side_capture;
				end
				if (has_sym) begin
					hd_info.symbol = head.symbol_capture;
					hd_info.symbol_length = 4'd8 - sp_cnt;
				end
			end
		end
	end

	// One compare-subtract against a constant per stage; quotient bits shift in.
	always_comb begin
		vld_in[0] = head_valid;
		rem_in[0] = head.time_stamp;
		quo_in[0] = '0;
		info_in[0] = hd_info;
		tm_in[0] = hd_tm;
		for (int k = 1; k < NSTEP; k++) begin
			vld_in[k] = vld_s[k-1];
			rem_in[k] = rem_s[k-1];
			quo_in[k] = quo_s[k-1];
			info_in[k] = info_s[k-1];
			tm_in[k] = tm_s[k-1];
		end
		for (int k = 0; k < NSTEP; k++) begin
			ge[k] = (rem_in[k] >= step_div(k));
			rem_nx[k] = ge[k] ? (rem_in[k] - step_div(k)) : rem_in[k];
			quo_nx[k] = {quo_in[k][QUO_W-2:0], ge[k]};
		end
	end

	// The last stage's quotient supplies the time fields of a timed result.
	always_comb begin
		res_nx = info_s[NSTEP-1];
		if (tm_s[NSTEP-1]) begin
			res_nx.hours = quo_s[NSTEP-1][28:22];
			res_nx.minutes = quo_s[NSTEP-1][21:16];
			res_nx.seconds = quo_s[NSTEP-1][15:10];
			res_nx.millis = quo_s[NSTEP-1][9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTEP; k++) begin
				vld_s[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			for (int k = 0; k < NSTEP; k++) begin
				vld_s[k] <= vld_in[k];
			end
			res_valid_q <= vld_s[NSTEP-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NSTEP; k++) begin
				rem_s[k] <= rem_nx[k];
				quo_s[k] <= quo_nx[k];
				info_s[k] <= info_in[k];
				tm_s[k] <= tm_in[k];
			end
			res_q <= res_nx;
		end
	end

endmodule

`default_nettype wire

// ===== sv/itchdp_checker.sv =====
// Port-level checks for the ITCH datagram parser, bound to its top level.
// Depends on itchdp_pkg and itch_datagram_parser.
`default_nettype none

module itchdp_checker import itchdp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire out_t res_data
);

	// A stalled result request holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// A runt carries nothing but its kind.
	a_runt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_RUNT |->
		res_data.message_length == '0 && res_data.type_byte == '0 && res_data.symbol == '0)
		else $error("runt result carries data");

	// The timestamp split stays within its ranges.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.hours <= 7'd78 && res_data.minutes < 6'd60 &&
		res_data.seconds < 6'd60 && res_data.millis < 10'd1000)
		else $error("timestamp field out of range");

	// Only messages with a symbol report a symbol length.
	a_symlen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind != KIND_ADD && res_data.kind != KIND_TRADE &&
		res_data.kind != KIND_DIR && res_data.kind != KIND_REPLACE |->
		res_data.symbol_length == '0 && res_data.symbol == '0)
		else $error("symbol reported for a kind without one");

	// Error kinds never carry captured detail fields.
	a_err_detail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.kind == KIND_UNKNOWN || res_data.kind == KIND_SHORT ||
		res_data.kind == KIND_INCOMPLETE || res_data.kind == KIND_EMPTY) |->
		res_data.evt_byte == '0 && res_data.side_code == '0 && res_data.hours == '0)
		else $error("error result carries detail fields");

endmodule

bind itch_datagram_parser itchdp_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data(res_data)
);

`default_nettype wire

// ===== sim/itch_datagram_parser_tb.sv =====
// Self-checking testbench for the ITCH datagram parser: drives datagram bytes with random bursts
// and stalls, predicts each per-datagram result and compares it field by field.
// Depends on itchdp_pkg and itch_datagram_parser.
`timescale 1ns / 100ps

module itch_datagram_parser_tb import itchdp_pkg::*; ();

	typedef logic [7:0] byte_q_t[$];

	localparam int DGRAM_LIMIT = 65536;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	in_t  byte_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	out_t res_data;

	itch_datagram_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1500000;
		$display("simulation failed");
		$finish;
	end

	// Shadow copy of the parser's per-datagram capture state.
	int          shadow_pos = 0;
	logic [15:0] shadow_len = '0;
	logic [7:0]  shadow_type = '0;
	logic [47:0] shadow_time = '0;
	logic [7:0]  shadow_side = '0;
	logic [7:0]  shadow_event = '0;
	logic [63:0] shadow_symbol = '0;

	out_t expected_results[$];

	int  mismatches = 0;
	int  burst_left = 0;
	bit  tx_gaps = 1'b1;
	bit  rx_stalls = 1'b1;
	int  hold_ticket = 0;
	int  hold_seen = 0;
	int  hold_cnt = 0;
	int  stall_cnt = 0;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch at time %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	function automatic out_t datagram_summary();
		out_t r;
		logic [47:0] t;
		bit has_time, has_side, has_event, has_sym;
		logic [15:0] minlen;
		logic [3:0] k;
		int sl;
		r = '0;
		has_time = 0;
		has_side = 0;
		has_event = 0;
		has_sym = 0;
		minlen = '0;
		k = KIND_UNKNOWN;
		if (shadow_pos < 2) begin
			r.kind = KIND_RUNT;
			return r;
		end
		r.message_length = shadow_len;
		if (shadow_pos < int'(shadow_len) + 2) begin
			r.kind = KIND_INCOMPLETE;
			if (shadow_pos >= 3)
				r.type_byte = shadow_type;
			return r;
		end
		if (shadow_len == 0) begin
			r.kind = KIND_EMPTY;
			return r;
		end
		r.type_byte = shadow_type;
		case (shadow_type)
			TYPE_SYS: begin
				k = KIND_SYS; minlen = MIN_SYS; has_time = 1; has_event = 1;
			end
			TYPE_ADD: begin
				k = KIND_ADD; minlen = MIN_ADD; has_time = 1; has_side = 1; has_sym = 1;
			end
			TYPE_TRADE: begin
				k = KIND_TRADE; minlen = MIN_TRADE; has_time = 1; has_side = 1; has_sym = 1;
			end
			TYPE_DIR: begin
				k = KIND_DIR; minlen = MIN_DIR; has_sym = 1;
			end
			TYPE_DELETE: begin
				k = KIND_DELETE; minlen = MIN_DELETE; has_time = 1;
			end
			TYPE_REPLACE: begin
				k = KIND_REPLACE; minlen = MIN_REPLACE; has_time = 1; has_side = 1; has_sym = 1;
			end
			TYPE_CANCEL: begin
				k = KIND_CANCEL; minlen = MIN_CANCEL; has_time = 1;
			end
			default: begin
				r.kind = KIND_UNKNOWN;
				return r;
			end
		endcase
		if (shadow_len < minlen) begin
			r.kind = KIND_SHORT;
			return r;
		end
		r.kind = k;
		if (has_time) begin
			t = shadow_time;
			r.hours = 7'(t / NS_HOUR);
			t = t % NS_HOUR;
			r.minutes = 6'(t / NS_MIN);
			t = t % NS_MIN;
			r.seconds = 6'(t / NS_SEC);
			r.millis = 10'((t % NS_SEC) / NS_MS);
		end
		if (has_event)
			r.evt_byte = shadow_event;
		if (has_side)
			r.side_code = shadow_side;
		if (has_sym) begin
			r.symbol = shadow_symbol;
			sl = 8;
			while (sl > 0 && ((shadow_symbol >> ((8 - sl) * 8)) & 64'hFF) == SPACE_CHAR)
				sl--;
			r.symbol_length = 4'(sl);
		end
		return r;
	endfunction

	task automatic track_accepted_byte(input logic [7:0] b, input logic last);
		bit sym_late;
		int p;
		p = shadow_pos;
		sym_late = (shadow_type == TYPE_ADD || shadow_type == TYPE_TRADE ||
			shadow_type == TYPE_REPLACE);
		// Bytes past the receive buffer are dropped and the count saturates.
		if (p < DGRAM_LIMIT) begin
			if (p == 0)
				shadow_len = {b, 8'h00};
			else if (p == 1)
				shadow_len[7:0] = b;
			else if (p == 2)
				shadow_type = b;
			if (p >= 7 && p <= 12)
				shadow_time = {shadow_time[39:0], b};
			if (p == 13)
				shadow_event = b;
			if (p == 21)
				shadow_side = b;
			if ((sym_late && p >= 26 && p <= 33) || (shadow_type == TYPE_DIR && p >= 3 && p <= 10))
				shadow_symbol = {shadow_symbol[55:0], b};
			shadow_pos = p + 1;
		end
		if (last) begin
			expected_results.push_back(datagram_summary());
			shadow_pos = 0;
			shadow_len = '0;
			shadow_type = '0;
			shadow_time = '0;
			shadow_side = '0;
			shadow_event = '0;
			shadow_symbol = '0;
		end
	endtask

	task automatic compare_result(input out_t got);
		out_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending, kind", got.kind, 0);
			return;
		end
		want = expected_results.pop_front();
		check_field("kind", got.kind, want.kind);
		check_field("message_length", got.message_length, want.message_length);
		check_field("type_byte", got.type_byte, want.type_byte);
		check_field("hours", got.hours, want.hours);
		check_field("minutes", got.minutes, want.minutes);
		check_field("seconds", got.seconds, want.seconds);
		check_field("millis", got.millis, want.millis);
		check_field("evt_byte", got.evt_byte, want.evt_byte);
		check_field("side_code", got.side_code, want.side_code);
		check_field("symbol", got.symbol, want.symbol);
		check_field("symbol_length", got.symbol_length, want.symbol_length);
	endtask

	// Result side: checks accepted results and drives ready. A long hold-off requested by a
	// test overrides the normal stall pattern.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			compare_result(res_data);
		if (hold_seen != hold_ticket) begin
			hold_seen = hold_ticket;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ready <= 1'b0;
		end else if (!rx_stalls) begin
			res_ready <= 1'b1;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			res_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_cnt = $urandom_range(0, 7);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic last);
		int gap;
		if (burst_left == 0) begin
			if (tx_gaps) begin
				gap = $urandom_range(1, 6);
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		byte_valid <= 1'b1;
		byte_data <= '{data_byte: value, datagram_end: last};
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		track_accepted_byte(value, last);
		burst_left--;
	endtask

	task automatic send_datagram(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	// Lays the fields of one message at their offsets over random filler, cut to n bytes.
	task automatic build_message(output byte_q_t q, input logic [7:0] mtype,
			input logic [15:0] len, input int n, input logic [47:0] ts, input logic [7:0] evt,
			input logic [7:0] side, input logic [63:0] sym);
		q = {};
		for (int i = 0; i < ((n > 34) ? n : 34); i++)
			q.push_back(8'($urandom));
		q[0] = len[15:8];
		q[1] = len[7:0];
		q[2] = mtype;
		for (int k = 0; k < 6; k++)
			q[7 + k] = ts[47 - 8 * k -: 8];
		q[13] = evt;
		q[21] = side;
		for (int k = 0; k < 8; k++) begin
			if (mtype == TYPE_DIR)
				q[3 + k] = sym[63 - 8 * k -: 8];
			else
				q[26 + k] = sym[63 - 8 * k -: 8];
		end
		while (q.size() > n)
			void'(q.pop_back());
	endtask

	task automatic send_message(input logic [7:0] mtype, input logic [15:0] len, input int n,
			input logic [47:0] ts, input logic [7:0] evt, input logic [7:0] side,
			input logic [63:0] sym);
		byte_q_t q;
		build_message(q, mtype, len, n, ts, evt, side, sym);
		send_datagram(q);
	endtask

	task automatic pick_known_type(input int idx, output logic [7:0] mtype,
			output logic [15:0] minlen);
		case (idx)
			0: begin mtype = TYPE_SYS; minlen = MIN_SYS; end
			1: begin mtype = TYPE_ADD; minlen = MIN_ADD; end
			2: begin mtype = TYPE_TRADE; minlen = MIN_TRADE; end
			3: begin mtype = TYPE_DIR; minlen = MIN_DIR; end
			4: begin mtype = TYPE_DELETE; minlen = MIN_DELETE; end
			5: begin mtype = TYPE_REPLACE; minlen = MIN_REPLACE; end
			default: begin mtype = TYPE_CANCEL; minlen = MIN_CANCEL; end
		endcase
	endtask

	function automatic logic [63:0] random_symbol();
		logic [63:0] s;
		int chars;
		if ($urandom_range(0, 7) == 0)
			return {$urandom, $urandom};
		chars = $urandom_range(0, 8);
		for (int k = 0; k < 8; k++)
			s[63 - 8 * k -: 8] = (k < chars) ? 8'($urandom_range(8'h41, 8'h5A)) : SPACE_CHAR;
		return s;
	endfunction

	function automatic logic [47:0] random_timestamp();
		longint unsigned t;
		if ($urandom_range(0, 1) == 0)
			return 48'({$urandom, $urandom});
		t = longint'($urandom_range(0, 86399999)) * 64'd1000000 + $urandom_range(0, 999999);
		return 48'(t);
	endfunction

	task automatic test_framing_edges();
		byte_q_t q;
		q = '{8'h00};
		send_datagram(q);
		q = '{8'hFF};
		send_datagram(q);
		q = '{8'h00, 8'h00};
		send_datagram(q);
		q = '{8'h00, 8'h00, TYPE_SYS, 8'hFF};
		send_datagram(q);
		q = '{8'h00, 8'h05};
		send_datagram(q);
		q = '{8'h00, 8'h05, TYPE_ADD};
		send_datagram(q);
		q = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_datagram(q);
		send_message(8'h5A, 16'd10, 12, random_timestamp(), 8'h00, 8'h00, random_symbol());
		send_message(8'h00, 16'd1, 3, '0, 8'h00, 8'h00, '0);
		send_message(8'hFF, 16'd40, 42, '1, 8'hFF, 8'hFF, '1);
	endtask

	task automatic test_each_message_type();
		send_message(TYPE_SYS, MIN_SYS, 14, 48'hFFFF_FFFF_FFFF, "O", 8'h00, '0);
		send_message(TYPE_SYS, MIN_SYS - 1, 13, random_timestamp(), "C", 8'h00, '0);
		send_message(TYPE_ADD, MIN_ADD, 38, '0, 8'h00, "B", "AAPL    ");
		send_message(TYPE_ADD, MIN_ADD - 1, 37, random_timestamp(), 8'h00, "S", "MSFT    ");
		// Bytes past the message length are still part of the datagram.
		send_message(TYPE_ADD, MIN_ADD, 45, random_timestamp(), 8'hFF, "S", random_symbol());
		send_message(TYPE_TRADE, MIN_TRADE, 46, random_timestamp(), 8'h00, "B", "        ");
		send_message(TYPE_TRADE, MIN_TRADE - 1, 45, random_timestamp(), 8'h00, "B", "IBM     ");
		send_message(TYPE_DIR, MIN_DIR, 24, '0, 8'h00, 8'h00, "ABCDEFGH");
		send_message(TYPE_DIR, MIN_DIR - 1, 23, '0, 8'h00, 8'h00, "ABCDEFGH");
		send_message(TYPE_DELETE, MIN_DELETE, 21, 48'd86399999999999, 8'h00, 8'h00, '0);
		send_message(TYPE_DELETE, MIN_DELETE - 1, 20, random_timestamp(), 8'h00, 8'h00, '0);
		send_message(TYPE_REPLACE, MIN_REPLACE, 37, random_timestamp(), 8'h00, "S", "A BC   D");
		send_message(TYPE_REPLACE, MIN_REPLACE - 1, 36, random_timestamp(), 8'h00, "S", '1);
		send_message(TYPE_CANCEL, MIN_CANCEL, 25, random_timestamp(), 8'h00, 8'h00, '0);
		send_message(TYPE_CANCEL, MIN_CANCEL - 1, 24, random_timestamp(), 8'h00, 8'h00, '0);
	endtask

	// Short datagrams pile up while the result side holds off, so the input must stall.
	task automatic test_output_backpressure();
		byte_q_t q;
		hold_ticket++;
		tx_gaps = 1'b0;
		for (int i = 0; i < 40; i++) begin
			if (i % 2 == 0)
				q = '{8'($urandom)};
			else
				q = '{8'h00, 8'h00};
			send_datagram(q);
		end
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		byte_q_t q;
		int sent_bytes, dgrams, pick, n;
		logic [15:0] len, minlen;
		logic [7:0] mtype;
		sent_bytes = 0;
		dgrams = 0;
		while (sent_bytes < 60) begin
			if ($urandom_range(0, 9) == 0)
				tx_gaps = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0)
				rx_stalls = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			pick_known_type($urandom_range(0, 6), mtype, minlen);
			if (pick < 60) begin
				len = minlen + 16'($urandom_range(0, 6));
				n = int'(len) + 2;
				if ($urandom_range(0, 3) == 0)
					n += $urandom_range(1, 4);
			end else if (pick < 72) begin
				len = 16'($urandom_range(1, minlen - 1));
				n = int'(len) + 2;
			end else if (pick < 82) begin
				len = 16'($urandom_range(1, 60));
				n = $urandom_range(1, int'(len) + 1);
			end else if (pick < 90) begin
				do
					mtype = 8'($urandom);
				while (mtype == TYPE_SYS || mtype == TYPE_ADD || mtype == TYPE_TRADE ||
					mtype == TYPE_DIR || mtype == TYPE_DELETE || mtype == TYPE_REPLACE ||
					mtype == TYPE_CANCEL);
				len = 16'($urandom_range(1, 40));
				n = int'(len) + 2;
			end else if (pick < 95) begin
				len = '0;
				n = $urandom_range(2, 5);
			end else begin
				len = 16'($urandom);
				mtype = 8'($urandom);
				n = $urandom_range(1, 40);
			end
			build_message(q, mtype, len, n, random_timestamp(), 8'($urandom), 8'($urandom),
				random_symbol());
			send_datagram(q);
			sent_bytes += n;
			dgrams++;
		end
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_framing_edges();
		test_each_message_type();
		test_output_backpressure();
		test_random_traffic();
		byte_valid <= 1'b0;
		for (int c = 0; c < DRAIN_LIMIT && expected_results.size() != 0; c++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered, count", expected_results.size(), 0);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/itchdp_pkg.sv
sv/itchdp_front.sv
sv/itchdp_fifo.sv
sv/itchdp_back.sv
sv/itch_datagram_parser.sv
sv/itchdp_checker.sv
sim/itch_datagram_parser_tb.sv
